[hw/rtl/gbs_pkg.sv]
package gbs_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_KEPT_DEF = 64;
  localparam int COORD_W_DEF  = 16;

  // Fixed field widths of the stream items
  localparam int FIELD_W  = 16;
  localparam int IDX_W    = 16;
  localparam int THR_W    = 9;
  localparam int THR_FRAC = 8;

  localparam logic [THR_W-1:0] THR_RESET = 9'd115;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPAN,
    ST_AREA,
    ST_LAUNCH,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  // Suppression flag that trails the box down the chain
  typedef struct packed {
    logic valid;
    logic hit;
  } flag_t;

endpackage

[hw/rtl/gbs_cell.sv]
module gbs_cell #(
  parameter int COORD_W  = gbs_pkg::COORD_W_DEF,
  parameter int CNT_W    = 7,
  parameter int CELL_IDX = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [4*COORD_W-1:0]      box_in,
  input  logic [2*COORD_W-1:0]      area_in,
  input  logic                      valid_in,
  input  logic [gbs_pkg::THR_W-1:0] thr,
  input  logic [CNT_W-1:0]          count,
  input  logic                      wr_en,
  input  logic [4*COORD_W-1:0]      wr_box,
  input  logic [2*COORD_W-1:0]      wr_area,
  input  gbs_pkg::flag_t            flag_in,
  output logic [4*COORD_W-1:0]      box_out,
  output logic [2*COORD_W-1:0]      area_out,
  output logic                      valid_out,
  output gbs_pkg::flag_t            flag_out
);
  import gbs_pkg::*;

  localparam int AW = 2 * COORD_W;
  localparam int UW = AW + 1;
  localparam int PW = UW + THR_W;

  // Box line stage and stored entry
  logic [4*COORD_W-1:0] box_r;
  logic [AW-1:0]        area_r;
  logic                 valid_r;
  logic [4*COORD_W-1:0] kbox_r;
  logic [AW-1:0]        karea_r;

  // Local compare pipeline
  logic [COORD_W-1:0] w1_r, h1_r;
  logic [UW-1:0]      asum1_r, asum2_r, uni3_r;
  logic [AW-1:0]      inter2_r, inter3_r, inter4_r;
  logic [PW-1:0]      prod4_r;
  logic               hit5_r;
  logic               v1_r, v2_r, v3_r, v4_r, v5_r;
  flag_t              flag_r;

  logic signed [COORD_W-1:0] n_top, n_left, n_bot, n_right;
  logic signed [COORD_W-1:0] k_top, k_left, k_bot, k_right;
  logic signed [COORD_W-1:0] lo_x, hi_x, lo_y, hi_y;
  logic signed [COORD_W:0]   dx, dy;
  logic [COORD_W-1:0]        w_c, h_c;
  logic                      active;
  logic                      slot_wr;

  assign n_top   = box_r[0*COORD_W +: COORD_W];
  assign n_left  = box_r[1*COORD_W +: COORD_W];
  assign n_bot   = box_r[2*COORD_W +: COORD_W];
  assign n_right = box_r[3*COORD_W +: COORD_W];
  assign k_top   = kbox_r[0*COORD_W +: COORD_W];
  assign k_left  = kbox_r[1*COORD_W +: COORD_W];
  assign k_bot   = kbox_r[2*COORD_W +: COORD_W];
  assign k_right = kbox_r[3*COORD_W +: COORD_W];

  // Intersection edges and clamped spans
  always_comb begin
    lo_x = (n_left > k_left) ? n_left : k_left;
    hi_x = (n_right < k_right) ? n_right : k_right;
    lo_y = (n_top > k_top) ? n_top : k_top;
    hi_y = (n_bot < k_bot) ? n_bot : k_bot;
    dx   = {hi_x[COORD_W-1], hi_x} - {lo_x[COORD_W-1], lo_x};
    dy   = {hi_y[COORD_W-1], hi_y} - {lo_y[COORD_W-1], lo_y};
    w_c  = (hi_x > lo_x) ? dx[COORD_W-1:0] : '0;
    h_c  = (hi_y > lo_y) ? dy[COORD_W-1:0] : '0;
  end

  // Only entries below the fill count take part
  assign active  = CNT_W'(CELL_IDX) < count;
  assign slot_wr = wr_en && (count == CNT_W'(CELL_IDX));

  // Advance valid bits and the flag chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      v5_r    <= 1'b0;
      flag_r  <= '0;
    end else begin
      valid_r      <= valid_in;
      v1_r         <= valid_r;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
      v4_r         <= v3_r;
      v5_r         <= v4_r;
      flag_r.valid <= v5_r;
      flag_r.hit   <= (flag_in.valid & flag_in.hit) | (v5_r & hit5_r);
    end
  end

  // Carry the box and run the overlap test
  always_ff @(posedge clk) begin
    box_r    <= box_in;
    area_r   <= area_in;
    w1_r     <= w_c;
    h1_r     <= h_c;
    asum1_r  <= UW'(area_r) + UW'(karea_r);
    inter2_r <= AW'(w1_r) * AW'(h1_r);
    asum2_r  <= asum1_r;
    uni3_r   <= asum2_r - UW'(inter2_r);
    inter3_r <= inter2_r;
    prod4_r  <= PW'(thr) * PW'(uni3_r);
    inter4_r <= inter3_r;
    hit5_r   <= active && ({{(PW-AW-THR_FRAC){1'b0}}, inter4_r, {THR_FRAC{1'b0}}} > prod4_r);
  end

  // Store a surviving box into this slot
  always_ff @(posedge clk) begin
    if (slot_wr) begin
      kbox_r  <= wr_box;
      karea_r <= wr_area;
    end
  end

  assign box_out   = box_r;
  assign area_out  = area_r;
  assign valid_out = valid_r;
  assign flag_out  = flag_r;

endmodule

[hw/rtl/greedy_box_suppression_unit.sv]
// Channel | Dir | Handshake             | Payload
// in      | in  | in_tvalid/in_tready   | tdata: top, left, bottom, right; tuser: first_of_set
// out     | out | out_tvalid/out_tready | tdata: item_index; tuser: kept, table_full
// cfg     | in  | cfg_valid/cfg_ready   | cfg_data: iou_threshold
//
// The box walks the cell chain one cell per cycle and each cell adds a five-stage overlap
// test. A new item is not accepted until the flag of the last cell has returned and the
// result has been taken into the output register, so the chain length sets the wait.
// A new item is accepted while the previous result waits in the output register.
// Reset is synchronous, active low; it empties the kept table and the item counter.
// Configuration writes are taken in any cycle.
module greedy_box_suppression_unit #(
  parameter int MAX_KEPT = gbs_pkg::MAX_KEPT_DEF,
  parameter int COORD_W  = gbs_pkg::COORD_W_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [63:0]               in_tdata,   // box_top, box_left, box_bottom, box_right
  input  logic [0:0]                in_tuser,   // first_of_set
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [15:0]               out_tdata,  // item_index
  output logic [1:0]                out_tuser,  // kept, table_full
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [gbs_pkg::THR_W-1:0] cfg_data
);
  import gbs_pkg::*;

  localparam int CNT_W = $clog2(MAX_KEPT + 1);
  localparam int AW    = 2 * COORD_W;
  localparam int BW    = 4 * COORD_W;

  state_t state_r, state_nxt;

  logic [THR_W-1:0]   thr_r;
  logic [CNT_W-1:0]   count_r;
  logic [IDX_W-1:0]   item_cnt_r;
  logic [IDX_W-1:0]   index_r;
  logic [BW-1:0]      box_r;
  logic [BW-1:0]      box_nxt;
  logic [COORD_W-1:0] w_r, h_r;
  logic [AW-1:0]      area_r;
  logic               survive_r;
  logic               out_valid_r;
  logic [IDX_W-1:0]   out_index_r;
  logic               out_kept_r;
  logic               out_full_r;

  logic               accept;
  logic               out_free;
  logic               decide_fire;
  logic               room;
  logic               head_valid;
  logic               wr_en;
  logic [IDX_W-1:0]   idx_base;

  logic signed [COORD_W-1:0] b_top, b_left, b_bot, b_right;
  logic signed [COORD_W:0]   dx, dy;
  logic [COORD_W-1:0]        w_c, h_c;

  logic [BW-1:0] box_line   [0:MAX_KEPT-1];
  logic [AW-1:0] area_line  [0:MAX_KEPT-1];
  logic          valid_line [0:MAX_KEPT-1];
  flag_t         flag_line  [0:MAX_KEPT];

  // Take each coordinate from its field, sign-extended or cut to COORD_W
  for (genvar k = 0; k < 4; k++) begin : g_coord
    if (COORD_W <= FIELD_W) begin : g_cut
      assign box_nxt[k*COORD_W +: COORD_W] = in_tdata[k*FIELD_W +: COORD_W];
    end else begin : g_ext
      assign box_nxt[k*COORD_W +: COORD_W] =
        {{(COORD_W-FIELD_W){in_tdata[k*FIELD_W+FIELD_W-1]}}, in_tdata[k*FIELD_W +: FIELD_W]};
    end
  end

  assign b_top   = box_r[0*COORD_W +: COORD_W];
  assign b_left  = box_r[1*COORD_W +: COORD_W];
  assign b_bot   = box_r[2*COORD_W +: COORD_W];
  assign b_right = box_r[3*COORD_W +: COORD_W];

  // Spans of the new box, clamped at zero
  always_comb begin
    dx  = {b_right[COORD_W-1], b_right} - {b_left[COORD_W-1], b_left};
    dy  = {b_bot[COORD_W-1], b_bot} - {b_top[COORD_W-1], b_top};
    w_c = (b_right > b_left) ? dx[COORD_W-1:0] : '0;
    h_c = (b_bot > b_top) ? dy[COORD_W-1:0] : '0;
  end

  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign room     = count_r < CNT_W'(MAX_KEPT);
  assign idx_base = in_tuser[0] ? '0 : item_cnt_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_SPAN;
      ST_SPAN:   state_nxt = ST_AREA;
      ST_AREA:   state_nxt = ST_LAUNCH;
      ST_LAUNCH: state_nxt = ST_SCAN;
      ST_SCAN:   if (flag_line[MAX_KEPT].valid) state_nxt = ST_DECIDE;
      ST_DECIDE: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_tready   = 1'b0;
    head_valid  = 1'b0;
    decide_fire = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_tready = 1'b1;
      ST_LAUNCH: head_valid = 1'b1;
      ST_DECIDE: decide_fire = out_free;
      default:   ;
    endcase
  end

  assign wr_en = decide_fire && survive_r && room;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      thr_r       <= THR_RESET;
      count_r     <= '0;
      item_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) thr_r <= cfg_data;
      if (accept) begin
        if (in_tuser[0]) count_r <= '0;
        item_cnt_r <= (idx_base == '1) ? idx_base : idx_base + 1'b1;
      end else if (wr_en) begin
        count_r <= count_r + 1'b1;
      end
      if (decide_fire) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Item payload and result
  always_ff @(posedge clk) begin
    if (accept) begin
      box_r   <= box_nxt;
      index_r <= idx_base;
    end
    if (state_r == ST_SPAN) begin
      w_r <= w_c;
      h_r <= h_c;
    end
    if (state_r == ST_AREA) area_r <= AW'(w_r) * AW'(h_r);
    if (state_r == ST_SCAN && flag_line[MAX_KEPT].valid) survive_r <= !flag_line[MAX_KEPT].hit;
    if (decide_fire) begin
      out_index_r <= index_r;
      out_kept_r  <= survive_r && room;
      out_full_r  <= survive_r && !room;
    end
  end

  assign flag_line[0] = '0;

  // Cell chain: the box moves one cell per cycle, the flag trails it
  for (genvar c = 0; c < MAX_KEPT; c++) begin : g_cell
    logic [BW-1:0] box_src;
    logic [AW-1:0] area_src;
    logic          valid_src;
    if (c == 0) begin : g_head
      assign box_src   = box_r;
      assign area_src  = area_r;
      assign valid_src = head_valid;
    end else begin : g_link
      assign box_src   = box_line[c-1];
      assign area_src  = area_line[c-1];
      assign valid_src = valid_line[c-1];
    end
    gbs_cell #(
      .COORD_W  (COORD_W),
      .CNT_W    (CNT_W),
      .CELL_IDX (c)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .box_in    (box_src),
      .area_in   (area_src),
      .valid_in  (valid_src),
      .thr       (thr_r),
      .count     (count_r),
      .wr_en     (wr_en),
      .wr_box    (box_r),
      .wr_area   (area_r),
      .flag_in   (flag_line[c]),
      .box_out   (box_line[c]),
      .area_out  (area_line[c]),
      .valid_out (valid_line[c]),
      .flag_out  (flag_line[c+1])
    );
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_index_r;
  assign out_tuser  = {out_full_r, out_kept_r};

endmodule

[hw/rtl/gbs_checker.sv]
module gbs_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic [63:0]               in_tdata,
  input logic [0:0]                in_tuser,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [15:0]               out_tdata,
  input logic [1:0]                out_tuser,
  input logic                      cfg_valid,
  input logic                      cfg_ready,
  input logic [gbs_pkg::THR_W-1:0] cfg_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // A box is never both stored and refused for lack of room
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("kept and table_full both set");

  // One box at a time: input closes after an accepted item
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input open right after an accepted item");

  // Reset drops any pending result
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind greedy_box_suppression_unit gbs_checker u_gbs_checker (.*);

[tb/greedy_box_suppression_unit_test.sv]
`timescale 1ns / 1ps

module greedy_box_suppression_unit_test;
  import gbs_pkg::*;

  localparam int KEPT_DEPTH  = MAX_KEPT_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 95;

  typedef struct {
    logic signed [FIELD_W-1:0] top;
    logic signed [FIELD_W-1:0] left;
    logic signed [FIELD_W-1:0] bottom;
    logic signed [FIELD_W-1:0] right;
    logic                      first_of_set;
  } box_item_t;

  typedef struct {
    longint top;
    longint left;
    longint bottom;
    longint right;
  } edges_t;

  typedef struct packed {
    logic             kept;
    logic [IDX_W-1:0] index;
    logic             table_full;
  } verdict_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [63:0]      in_tdata   = '0;  // box_top, box_left, box_bottom, box_right
  logic [0:0]       in_tuser   = '0;  // first_of_set
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [15:0]      out_tdata;        // item_index
  logic [1:0]       out_tuser;        // kept, table_full
  logic             cfg_valid  = 1'b0;
  logic             cfg_ready;
  logic [THR_W-1:0] cfg_data   = '0;

  // Stimulus and expectation stores
  box_item_t pending_boxes[$];
  verdict_t  expected_verdicts[$];

  // Shadow of the block's suppression state
  edges_t           kept_edges[KEPT_DEPTH];
  longint           kept_area[KEPT_DEPTH];
  int               kept_num      = 0;
  int               next_index    = 0;
  logic [THR_W-1:0] iou_limit     = THR_RESET;

  int   error_count  = 0;
  int   quiet_cycles = 0;
  logic steady_flow  = 1'b0;

  greedy_box_suppression_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint clamped_span(longint lo, longint hi);
    return (hi > lo) ? hi - lo : 64'sd0;
  endfunction

  function automatic longint overlap_area(edges_t a, edges_t b);
    longint l, r, t, bo;
    if (a.top > b.bottom || a.bottom < b.top || a.left > b.right || a.right < b.left)
      return 64'sd0;
    l  = (a.left > b.left) ? a.left : b.left;
    r  = (a.right < b.right) ? a.right : b.right;
    t  = (a.top > b.top) ? a.top : b.top;
    bo = (a.bottom < b.bottom) ? a.bottom : b.bottom;
    return clamped_span(l, r) * clamped_span(t, bo);
  endfunction

  // Run one box through the greedy suppression and update the kept table
  function automatic verdict_t predict_suppression(box_item_t bx);
    edges_t   e;
    longint   area, inter, uni;
    logic     survive;
    verdict_t v;
    survive = 1'b1;
    if (bx.first_of_set) begin
      kept_num   = 0;
      next_index = 0;
    end
    e.top    = longint'(bx.top);
    e.left   = longint'(bx.left);
    e.bottom = longint'(bx.bottom);
    e.right  = longint'(bx.right);
    area = clamped_span(e.left, e.right) * clamped_span(e.top, e.bottom);
    for (int j = 0; j < kept_num; j++) begin
      inter = overlap_area(e, kept_edges[j]);
      uni   = area + kept_area[j] - inter;
      if (survive && inter * 256 > longint'(iou_limit) * uni)
        survive = 1'b0;
    end
    v.index = next_index[IDX_W-1:0];
    if (next_index < 65535)
      next_index++;
    v.kept       = 1'b0;
    v.table_full = 1'b0;
    if (survive) begin
      if (kept_num < KEPT_DEPTH) begin
        kept_edges[kept_num] = e;
        kept_area[kept_num]  = area;
        kept_num++;
        v.kept = 1'b1;
      end else begin
        v.table_full = 1'b1;
      end
    end
    return v;
  endfunction

  // Drive boxes from the pending queue; predict at acceptance
  always @(posedge clk) begin : box_driver
    box_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        nxt.top          = in_tdata[15:0];
        nxt.left         = in_tdata[31:16];
        nxt.bottom       = in_tdata[47:32];
        nxt.right        = in_tdata[63:48];
        nxt.first_of_set = in_tuser[0];
        expected_verdicts.insert(expected_verdicts.size(), predict_suppression(nxt));
      end
      if (!in_tvalid || in_tready) begin
        if (pending_boxes.size() != 0 && (steady_flow || $urandom_range(99) >= 17)) begin
          nxt = pending_boxes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {nxt.right, nxt.bottom, nxt.left, nxt.top};
          in_tuser  <= nxt.first_of_set;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Stall the result side at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady_flow || ($urandom_range(99) >= 17);
    end
  end

  // Compare each result item with the oldest expectation
  always @(posedge clk) begin : verdict_monitor
    verdict_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.kept       = out_tuser[0];
      got.table_full = out_tuser[1];
      got.index      = out_tdata;
      if (expected_verdicts.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result kept=%0d index=%0d table_full=%0d",
                 $realtime, got.kept, got.index, got.table_full);
      end else begin
        want = expected_verdicts.pop_front();
        if (got.kept !== want.kept || got.index !== want.index ||
            got.table_full !== want.table_full) begin
          error_count++;
          $display("%0t: expected kept=%0d idx=%0d full=%0d got kept=%0d idx=%0d full=%0d",
                   $realtime, want.kept, want.index, want.table_full,
                   got.kept, got.index, got.table_full);
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic queue_box(input int top, input int left,
                           input int bottom, input int right,
                           input logic first_of_set);
    box_item_t bx;
    bx.top          = FIELD_W'(top);
    bx.left         = FIELD_W'(left);
    bx.bottom       = FIELD_W'(bottom);
    bx.right        = FIELD_W'(right);
    bx.first_of_set = first_of_set;
    pending_boxes.insert(pending_boxes.size(), bx);
  endtask

  // Hold off until the block has returned every expected result
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_boxes.size() != 0 || in_tvalid || expected_verdicts.size() != 0);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    iou_limit = value;
  endtask

  // One set of mostly clustered boxes, with some noise mixed in
  task automatic queue_random_set(input int count);
    int cx[3], cy[3];
    int kind, c, w, h, t, l;
    for (int k = 0; k < 3; k++) begin
      cx[k] = int'($urandom_range(8000)) - 4000;
      cy[k] = int'($urandom_range(8000)) - 4000;
    end
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(99);
      c    = $urandom_range(2);
      w    = $urandom_range(32, 1200);
      h    = $urandom_range(32, 1200);
      if (kind < 60) begin
        t = cy[c] - h / 2 + int'($urandom_range(200)) - 100;
        l = cx[c] - w / 2 + int'($urandom_range(200)) - 100;
        queue_box(t, l, t + h, l + w, i == 0);
      end else if (kind < 75) begin
        t = int'($urandom_range(8000)) - 4000;
        l = int'($urandom_range(8000)) - 4000;
        queue_box(t, l, t + h, l + w, i == 0);
      end else if (kind < 85) begin
        // inverted in one or both directions
        t = cy[c];
        l = cx[c];
        queue_box(t, l, t - $urandom_range(h), l + w - $urandom_range(2 * w), i == 0);
      end else if (kind < 95) begin
        queue_box($urandom, $urandom, $urandom, $urandom, i == 0 || $urandom_range(19) == 0);
      end else begin
        // zero width
        t = cy[c];
        l = cx[c];
        queue_box(t, l, t + h, l, i == 0);
      end
    end
  endtask

  task automatic queue_random_phase(input int target);
    int n;
    n = 0;
    while (n < target) begin
      c_len: begin
        int len;
        len = $urandom_range(1, 24);
        queue_random_set(len);
        n += len;
      end
    end
  endtask

  initial begin
    int t, l;
    for (int j = 0; j < KEPT_DEPTH; j++) begin
      kept_edges[j] = '{0, 0, 0, 0};
      kept_area[j]  = 0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed boxes under the reset threshold
    queue_box(0, 0, 160, 160, 1'b1);
    queue_box(0, 0, 160, 160, 1'b0);       // identical box
    queue_box(0, 160, 160, 320, 1'b0);     // touching edge
    queue_box(0, 80, 160, 240, 1'b0);      // one third overlap
    queue_box(16, 16, 160, 160, 1'b0);     // mostly inside the first
    queue_box(100, 500, 50, 600, 1'b0);    // inverted height
    queue_box(100, 500, 50, 600, 1'b0);    // zero union
    queue_box(200, 200, 400, 200, 1'b0);   // zero width
    queue_box('h8000, 'h8000, 'h7FFF, 'h7FFF, 1'b0);
    queue_box('h8000, 'h8000, 'h7FFF, 'h7FFF, 1'b0);
    queue_box('h7FFF, 'h7FFF, 'h8000, 'h8000, 1'b0);
    queue_box('h8000, 'h8000, 'h8010, 'h8010, 1'b1);
    queue_box('hAAAA, 'hAAAA, 'h5555, 'h5555, 1'b0);
    queue_box('h7FF0, 'h7FF0, 'h7FFF, 'h7FFF, 1'b0);
    // just above and just below the reset threshold
    queue_box(0, 0, 256, 256, 1'b1);
    queue_box(0, 97, 256, 353, 1'b0);
    queue_box(0, 98, 256, 354, 1'b0);
    wait_drained();

    // Fill the kept table with disjoint boxes, then overflow it
    write_threshold(9'd0);
    for (int k = 0; k < KEPT_DEPTH + 6; k++) begin
      t = (k / 9) * 256 - 20000;
      l = (k % 9) * 256 - 20000;
      queue_box(t, l, t + $urandom_range(1, 256), l + $urandom_range(1, 256), k == 0);
    end
    queue_box(-20000, -20000, -17000, -17000, 1'b0);
    queue_box(20000, 20000, 20100, 20100, 1'b0);
    queue_random_phase(PHASE_ITEMS);
    wait_drained();

    // Never suppress; no idling on either side
    steady_flow = 1'b1;
    write_threshold(9'd256);
    queue_random_phase(PHASE_ITEMS);
    wait_drained();
    steady_flow = 1'b0;

    write_threshold(THR_W'($urandom_range(1, 255)));
    queue_random_phase(PHASE_ITEMS);
    wait_drained();

    write_threshold(9'd128);
    queue_random_phase(PHASE_ITEMS);
    wait_drained();

    write_threshold(THR_RESET);
    queue_random_phase(PHASE_ITEMS);
    wait_drained();

    write_threshold(9'd255);
    queue_random_phase(PHASE_ITEMS);
    wait_drained();

    // Watch for stray results after the last expected one
    repeat (KEPT_DEPTH + 20) @(posedge clk);
    if (error_count == 0 && expected_verdicts.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[greedy_box_suppression_unit.f]
hw/rtl/gbs_pkg.sv
hw/rtl/gbs_cell.sv
hw/rtl/greedy_box_suppression_unit.sv
hw/rtl/gbs_checker.sv
tb/greedy_box_suppression_unit_test.sv
